>>> src/hcb_pkg.sv
// Shared constants, codes and controller/datapath interface types of the Hill cipher block.
`timescale 1ns / 1ps

package hcb_pkg;

   localparam int LETTER_W = 5;
   localparam int KEY_W    = 45;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KEY_MATRIX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION  = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADJ,
      OP_DET,
      OP_INV,
      OP_MAC
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] row;
      logic [1:0] col;
      logic       capture;
      logic       load_out;
      logic       out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic order3;
      logic decrypt;
      logic block_done;
      logic out_free;
   } dp_status_type;

endpackage

>>> src/hcb_ctrl.sv
// Controller state machine: letter capture, adjugate, determinant, inverse and row products.
`timescale 1ns / 1ps

module hcb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hcb_pkg::dp_status_type sts,
   output hcb_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADJ,
      S_DET,
      S_INV,
      S_MAC,
      S_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0] row_ff;
   logic [1:0] col_ff;
   logic [1:0] last;
   logic       det_end;

   assign last    = sts.order3 ? 2'd2 : 2'd1;
   assign det_end = !sts.order3 || (col_ff >= 2'd2);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd.row      = row_ff;
      cmd.col      = col_ff;
      cmd.capture  = (state_ff == S_IDLE) && req_valid;
      cmd.load_out = (state_ff == S_OUT) && sts.out_free;
      cmd.out_last = (row_ff >= last);
      unique case (state_ff)
         S_ADJ:   cmd.op = hcb_pkg::OP_ADJ;
         S_DET:   cmd.op = hcb_pkg::OP_DET;
         S_INV:   cmd.op = hcb_pkg::OP_INV;
         S_MAC:   cmd.op = hcb_pkg::OP_MAC;
         default: cmd.op = hcb_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.capture && sts.block_done) begin
                  row_ff   <= 2'd0;
                  col_ff   <= 2'd0;
                  state_ff <= sts.decrypt ? S_ADJ : S_MAC;
               end
            end
            S_ADJ, S_INV: begin
               if (col_ff >= last) begin
                  col_ff <= 2'd0;
                  if (row_ff >= last) begin
                     row_ff   <= 2'd0;
                     state_ff <= (state_ff == S_ADJ) ? S_DET : S_MAC;
                  end else begin
                     row_ff <= row_ff + 2'd1;
                  end
               end else begin
                  col_ff <= col_ff + 2'd1;
               end
            end
            S_DET: begin
               if (det_end) begin
                  col_ff   <= 2'd0;
                  state_ff <= S_INV;
               end else begin
                  col_ff <= col_ff + 2'd1;
               end
            end
            S_MAC: begin
               if (col_ff >= last) begin
                  state_ff <= S_OUT;
               end else begin
                  col_ff <= col_ff + 2'd1;
               end
            end
            S_OUT: begin
               if (sts.out_free) begin
                  col_ff <= 2'd0;
                  if (row_ff >= last) begin
                     row_ff   <= 2'd0;
                     state_ff <= S_IDLE;
                  end else begin
                     row_ff   <= row_ff + 2'd1;
                     state_ff <= S_MAC;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (row_ff != 2'd3 && col_ff != 2'd3))
      else $error("matrix index out of range");

   a_block_starts_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && cmd.capture && sts.block_done) |=>
      (state_ff == S_ADJ || state_ff == S_MAC))
      else $error("completed block did not start computation");

   a_last_row_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && sts.out_free && row_ff >= last) |=> (state_ff == S_IDLE))
      else $error("last row emitted but controller not idle");

endmodule

>>> src/hcb_datapath.sv
// Datapath: configuration registers, letter buffer, shared mod-26 product unit, output register.
`timescale 1ns / 1ps

module hcb_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hcb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hcb_pkg::KEY_W-1:0]       csr_wdata,
   input  logic [hcb_pkg::LETTER_W-1:0]    req_letter_in,
   input  logic                            req_end_of_message,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hcb_pkg::LETTER_W-1:0]    rsp_letter_out,
   output logic                            rsp_block_last,
   output logic                            rsp_key_error,
   input  hcb_pkg::dp_cmd_type             cmd,
   output hcb_pkg::dp_status_type          sts
);

   localparam logic [4:0] PAD_LETTER = 5'd23;

   // residue mod 26 of an 11-bit value by folding 32 = 6 (mod 26)
   function automatic logic [4:0] red26(input logic [10:0] v);
      logic [8:0] w;
      logic [6:0] x;
      logic [5:0] y;
      w = 9'(v[10:5]) * 9'd6 + 9'(v[4:0]);
      x = 7'(w[8:5]) * 7'd6 + 7'(w[4:0]);
      y = 6'(x[6:5]) * 6'd6 + 6'(x[4:0]);
      return (y >= 6'd26) ? 5'(y - 6'd26) : y[4:0];
   endfunction

   function automatic logic [4:0] inv26(input logic [4:0] d);
      case (d)
         5'd1:    return 5'd1;
         5'd3:    return 5'd9;
         5'd5:    return 5'd21;
         5'd7:    return 5'd15;
         5'd9:    return 5'd3;
         5'd11:   return 5'd19;
         5'd15:   return 5'd7;
         5'd17:   return 5'd23;
         5'd19:   return 5'd11;
         5'd21:   return 5'd5;
         5'd23:   return 5'd17;
         5'd25:   return 5'd25;
         default: return 5'd0;
      endcase
   endfunction

   function automatic logic [1:0] inc3(input logic [1:0] i);
      return (i >= 2'd2) ? 2'd0 : i + 2'd1;
   endfunction

   logic [hcb_pkg::KEY_W-1:0] key_ff;
   logic [1:0]                bsize_ff;
   logic                      dir_ff;
   logic [4:0]                buf_ff [3];
   logic [1:0]                fill_ff;
   logic [4:0]                adj_ff [3][3];
   logic [4:0]                det_ff;
   logic [4:0]                acc_ff;
   logic                      valid_ff;
   logic [4:0]                letter_ff;
   logic                      last_ff;
   logic                      err_ff;

   logic [4:0]  km [3][3];
   logic [4:0]  letter_red;
   logic [1:0]  fill_inc;
   logic [1:0]  order;
   logic        key_bad;
   logic [4:0]  op_acc, op_a, op_b, op_c, op_d;
   logic [9:0]  prod_ab, prod_cd;
   logic [10:0] sum;
   logic [4:0]  res;
   logic [1:0]  i1, i2, j1, j2;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         bsize_ff <= 2'd2;
         dir_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            hcb_pkg::REG_KEY_MATRIX: key_ff   <= csr_wdata;
            hcb_pkg::REG_BLOCK_SIZE: bsize_ff <= csr_wdata[1:0];
            hcb_pkg::REG_DIRECTION:  dir_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            km[r][c] = red26({6'b0, key_ff[5*(3*r+c) +: 5]});
         end
      end
   end

   assign order      = (bsize_ff == 2'd3) ? 2'd3 : 2'd2;
   assign letter_red = red26({6'b0, req_letter_in});
   assign fill_inc   = fill_ff + 2'd1;
   assign key_bad    = dir_ff && (!det_ff[0] || det_ff == 5'd13);

   assign sts.order3     = (order == 2'd3);
   assign sts.decrypt    = dir_ff;
   assign sts.block_done = (fill_inc >= order) || req_end_of_message;
   assign sts.out_free   = !valid_ff || !rsp_stall;

   // letter buffer; a completed block is padded up to the order in the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else if (cmd.capture) begin
         fill_ff <= sts.block_done ? 2'd0 : fill_inc;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.capture) begin
            if (2'(i) == fill_ff) begin
               buf_ff[i] <= letter_red;
            end else if (sts.block_done && 2'(i) > fill_ff && 2'(i) < order) begin
               buf_ff[i] <= PAD_LETTER;
            end
         end
      end
   end

   // cofactor index rotation; adjugate entry (row, col) is the cofactor of (col, row)
   assign j1 = inc3(cmd.row);
   assign j2 = inc3(j1);
   assign i1 = inc3(cmd.col);
   assign i2 = inc3(i1);

   always_comb begin
      op_acc = 5'd0;
      op_a   = 5'd0;
      op_b   = 5'd0;
      op_c   = 5'd0;
      op_d   = 5'd0;
      unique case (cmd.op)
         hcb_pkg::OP_ADJ: begin
            if (sts.order3) begin
               op_a = km[i1][j1];
               op_b = km[i2][j2];
               op_c = km[i1][j2];
               op_d = km[i2][j1];
            end else begin
               case ({cmd.row[0], cmd.col[0]})
                  2'b00: begin
                     op_a = km[1][1];
                     op_b = 5'd1;
                  end
                  2'b01: begin
                     op_c = km[0][1];
                     op_d = 5'd1;
                  end
                  2'b10: begin
                     op_c = km[1][0];
                     op_d = 5'd1;
                  end
                  default: begin
                     op_a = km[0][0];
                     op_b = 5'd1;
                  end
               endcase
            end
         end
         hcb_pkg::OP_DET: begin
            if (sts.order3) begin
               op_acc = (cmd.col == 2'd0) ? 5'd0 : det_ff;
               op_a   = km[0][cmd.col];
               op_b   = adj_ff[cmd.col][0];
            end else begin
               op_a = km[0][0];
               op_b = km[1][1];
               op_c = km[1][0];
               op_d = km[0][1];
            end
         end
         hcb_pkg::OP_INV: begin
            op_a = adj_ff[cmd.row][cmd.col];
            op_b = inv26(det_ff);
         end
         hcb_pkg::OP_MAC: begin
            op_acc = (cmd.col == 2'd0) ? 5'd0 : acc_ff;
            op_a   = dir_ff ? adj_ff[cmd.row][cmd.col] : km[cmd.row][cmd.col];
            op_b   = buf_ff[cmd.col];
         end
         default: ;
      endcase
   end

   // acc + a*b - c*d, kept positive by adding 676 (a multiple of 26)
   assign prod_ab = op_a * op_b;
   assign prod_cd = op_c * op_d;
   assign sum = {6'b0, op_acc} + {1'b0, prod_ab} + (11'd676 - {1'b0, prod_cd});
   assign res = red26(sum);

   always_ff @(posedge clock) begin
      case (cmd.op)
         hcb_pkg::OP_ADJ, hcb_pkg::OP_INV: adj_ff[cmd.row][cmd.col] <= res;
         hcb_pkg::OP_DET:                  det_ff <= res;
         hcb_pkg::OP_MAC:                  acc_ff <= res;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         letter_ff <= key_bad ? 5'd0 : acc_ff;
         last_ff   <= cmd.out_last;
         err_ff    <= key_bad;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_letter_out = letter_ff;
   assign rsp_block_last = last_ff;
   assign rsp_key_error  = err_ff;

   a_fill_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && sts.block_done) |=> (fill_ff == 2'd0))
      else $error("fill count not cleared after a completed block");

endmodule

>>> src/hill_cipher_block_top.sv
// Top level of the Hill cipher block (mod 26, order 2 or 3).
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    letter_in, end_of_message
//  rsp      out        rsp_valid/stall    letter_out, block_last, key_error
//  csr      in         csr_valid/ready    csr_index, csr_wdata
//
// A letter that does not complete a block is taken without a stall. A completed block of
// n letters runs through one shared mod-26 product unit: n*n row product steps plus an
// output step per row, which waits while the output register is stalled; decrypt adds n*n
// adjugate, n determinant (one for order 2) and n*n inverse steps.
// Synchronous active-high reset; the letter buffer needs no clearing.
// Input is stalled while a block is computed; a row waiting in the output register
// holds the sequence, but the next letter is taken once the last row is registered.
`timescale 1ns / 1ps

module hill_cipher_block_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hcb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hcb_pkg::KEY_W-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hcb_pkg::LETTER_W-1:0]  req_letter_in,
   input  logic                          req_end_of_message,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hcb_pkg::LETTER_W-1:0]  rsp_letter_out,
   output logic                          rsp_block_last,
   output logic                          rsp_key_error
);

   hcb_pkg::dp_cmd_type    cmd;
   hcb_pkg::dp_status_type sts;

   hcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   hcb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_letter_in      (req_letter_in),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_letter_out     (rsp_letter_out),
      .rsp_block_last     (rsp_block_last),
      .rsp_key_error      (rsp_key_error),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule
